// ===== rtl/core/cst_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Tokenizer package
// Shared token kinds, scan modes, the record that passes from the front
// part to the result queue, and the keyword lookup.
// ---------------------------------------------------------------------------
package cst_pkg;

   typedef enum logic [2:0] {
      KIND_END     = 3'd0,
      KIND_KEYWORD = 3'd1,
      KIND_IDENT   = 3'd2,
      KIND_NUMBER  = 3'd3,
      KIND_STRING  = 3'd4,
      KIND_SYMBOL  = 3'd5,
      KIND_UNKNOWN = 3'd6
   } kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'd0,
      MODE_SLASH  = 4'd1,
      MODE_LINE   = 4'd2,
      MODE_BLOCK  = 4'd3,
      MODE_STAR   = 4'd4,
      MODE_HASH   = 4'd5,
      MODE_STRING = 4'd6,
      MODE_WORD   = 4'd7,
      MODE_DIGITS = 4'd8
   } mode_type;

   // One token as it travels through the result queue.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] line;
      logic [15:0] column;
      logic [15:0] offset;
      logic [15:0] length;
      logic [7:0]  first;
      logic        last;
   } token_type;

   localparam int TokenBits = $bits(token_type);

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      is_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      is_digit = b >= "0" && b <= "9";
   endfunction

   function automatic logic is_symbol(input logic [7:0] b);
      is_symbol = b == "(" || b == ")" || b == "{" || b == "}" || b == "[" ||
                  b == "]" || b == ";" || b == ",";
   endfunction

   // Pack a string literal little-endian, first byte in the low bits.
   function automatic logic [63:0] kw(input logic [63:0] s, input int n);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < n) r[8*i +: 8] = s[8*(n-1-i) +: 8];
      end
      kw = r;
   endfunction

   // Parallel compare of the held prefix against the keyword table.
   function automatic logic is_keyword(input logic [63:0] p, input logic [15:0] len);
      logic [63:0] m;
      logic hit;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (16'(i) < len) m[8*i +: 8] = p[8*i +: 8];
      end
      hit = 1'b0;
      case (len)
         16'd2: hit = m == kw("if", 2) || m == kw("do", 2);
         16'd3: hit = m == kw("int", 3) || m == kw("for", 3);
         16'd4: hit = m == kw("char", 4) || m == kw("void", 4) ||
                      m == kw("long", 4) || m == kw("else", 4) ||
                      m == kw("case", 4) || m == kw("goto", 4) ||
                      m == kw("auto", 4) || m == kw("enum", 4) ||
                      m == kw("free", 4) || m == kw("exit", 4) ||
                      m == kw("main", 4);
         16'd5: hit = m == kw("float", 5) || m == kw("short", 5) ||
                      m == kw("while", 5) || m == kw("break", 5) ||
                      m == kw("const", 5) || m == kw("union", 5) ||
                      m == kw("scanf", 5);
         16'd6: hit = m == kw("double", 6) || m == kw("signed", 6) ||
                      m == kw("switch", 6) || m == kw("return", 6) ||
                      m == kw("static", 6) || m == kw("extern", 6) ||
                      m == kw("struct", 6) || m == kw("sizeof", 6) ||
                      m == kw("printf", 6) || m == kw("malloc", 6) ||
                      m == kw("strlen", 6) || m == kw("strcpy", 6) ||
                      m == kw("strcmp", 6);
         16'd7: hit = m == kw("default", 7) || m == kw("typedef", 7);
         16'd8: hit = m == kw("unsigned", 8) || m == kw("continue", 8) ||
                      m == kw("register", 8) || m == kw("volatile", 8);
         default: hit = 1'b0;
      endcase
      is_keyword = hit;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cst_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module cst_ram #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/core/cst_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Tokenizer front part
// Classifies each byte, keeps the scan state and forms up to two tokens.
// ---------------------------------------------------------------------------
module cst_front
   import cst_pkg::*;
#(
   parameter int TextLimit = 65536
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,
   input  wire logic [7:0] text_byte,
   input  wire logic       end_of_text,
   output logic      [1:0] tok_count,
   output token_type       tok_a,
   output token_type       tok_b
);

   localparam int CountBits = $clog2(TextLimit) + 1;

   mode_type    mode_ff, mode_in;
   logic [15:0] line_ff, line_in, col_ff, col_in, pos_ff, pos_in;
   logic [15:0] sline_ff, sline_in, scol_ff, scol_in, spos_ff, spos_in;
   logic [15:0] plen_ff, plen_in;
   logic [63:0] prefix_ff, prefix_in;
   logic [7:0]  lead_ff, lead_in;
   logic [CountBits-1:0] taken_ff, taken_in;

   // Scan step: pending flush, fresh byte and counter updates.
   always_comb begin
      logic      do_flush, do_fresh, fl_ok, fr_ok;
      kind_type  fl_kind;
      token_type fl, fr;
      logic [7:0] b;
      b = text_byte;
      mode_in = mode_ff; line_in = line_ff; col_in = col_ff; pos_in = pos_ff;
      sline_in = sline_ff; scol_in = scol_ff; spos_in = spos_ff;
      plen_in = plen_ff; prefix_in = prefix_ff; lead_in = lead_ff;
      taken_in = taken_ff;
      do_flush = 1'b0; do_fresh = 1'b0; fr_ok = 1'b0;
      fl_ok = 1'b1;
      case (mode_ff)
         MODE_WORD:   fl_kind = is_keyword(prefix_ff, plen_ff) ? KIND_KEYWORD : KIND_IDENT;
         MODE_DIGITS: fl_kind = KIND_NUMBER;
         MODE_STRING: fl_kind = KIND_STRING;
         MODE_SLASH:  fl_kind = KIND_UNKNOWN;
         default: begin
            fl_kind = KIND_END;
            fl_ok = 1'b0;
         end
      endcase
      fl = '{fl_kind, sline_ff, scol_ff, spos_ff, plen_ff, lead_ff, 1'b0};
      fr = '{is_symbol(b) ? KIND_SYMBOL : KIND_UNKNOWN, line_ff, col_ff, pos_ff,
             16'd1, b, 1'b0};
      tok_count = 2'd0;
      tok_a = fl;
      tok_b = fr;
      if (end_of_text || b == 8'd0) begin
         if (fl_ok) begin
            tok_count = 2'd2;
            tok_b = '{KIND_END, line_ff, col_ff, pos_ff, 16'd0, 8'd0, 1'b1};
         end else begin
            tok_count = 2'd1;
            tok_a = '{KIND_END, line_ff, col_ff, pos_ff, 16'd0, 8'd0, 1'b1};
         end
         mode_in = MODE_IDLE; line_in = 16'd1; col_in = 16'd1; pos_in = '0;
         sline_in = 16'd1; scol_in = 16'd1; spos_in = '0; plen_in = '0;
         prefix_in = '0; lead_in = '0; taken_in = '0;
      end else if (taken_ff < CountBits'(TextLimit - 1)) begin
         case (mode_ff)
            MODE_SLASH: begin
               if (b == "/") mode_in = MODE_LINE;
               else if (b == "*") mode_in = MODE_BLOCK;
               else begin
                  do_flush = 1'b1;
                  do_fresh = 1'b1;
               end
            end
            MODE_LINE, MODE_HASH: if (b == 8'h0A) mode_in = MODE_IDLE;
            MODE_BLOCK: if (b == "*") mode_in = MODE_STAR;
            MODE_STAR: begin
               if (b == "/") mode_in = MODE_IDLE;
               else if (b != "*") mode_in = MODE_BLOCK;
            end
            MODE_STRING: begin
               if (plen_ff < 16'd8) prefix_in[8*plen_ff[2:0] +: 8] = b;
               plen_in = sat_inc(plen_ff);
               if (b == "\"") begin
                  tok_a.length = plen_in;
                  tok_count = 2'd1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_WORD, MODE_DIGITS: begin
               if (is_digit(b) || (mode_ff == MODE_WORD && is_alpha(b))) begin
                  if (plen_ff < 16'd8) prefix_in[8*plen_ff[2:0] +: 8] = b;
                  plen_in = sat_inc(plen_ff);
               end else begin
                  do_flush = 1'b1;
                  do_fresh = 1'b1;
               end
            end
            default: do_fresh = 1'b1;
         endcase
         if (do_fresh) begin
            if (do_flush) mode_in = MODE_IDLE;
            if (b == " " || b == 8'h09 || b == 8'h0A) mode_in = MODE_IDLE;
            else if (b == "#") mode_in = MODE_HASH;
            else if (b == "/" || b == "\"" || is_alpha(b) || is_digit(b)) begin
               mode_in = (b == "/") ? MODE_SLASH : (b == "\"") ? MODE_STRING :
                         is_alpha(b) ? MODE_WORD : MODE_DIGITS;
               sline_in = line_ff; scol_in = col_ff; spos_in = pos_ff;
               plen_in = 16'd1; prefix_in = {56'd0, b}; lead_in = b;
            end else begin
               mode_in = MODE_IDLE;
               fr_ok = 1'b1;
            end
            if (do_flush && fr_ok) tok_count = 2'd2;
            else if (do_flush) tok_count = 2'd1;
            else if (fr_ok) begin
               tok_count = 2'd1;
               tok_a = fr;
            end
         end
         taken_in = taken_ff + 1'b1;
         pos_in = sat_inc(pos_ff);
         if (b == 8'h0A) begin
            line_in = sat_inc(line_ff);
            col_in = 16'd1;
         end else col_in = sat_inc(col_ff);
      end
      if (tok_count == 2'd1) tok_a.last = 1'b1;
      if (tok_count == 2'd2) tok_b.last = 1'b1;
   end

   // Scan state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE; line_ff <= 16'd1; col_ff <= 16'd1; pos_ff <= '0;
         sline_ff <= 16'd1; scol_ff <= 16'd1; spos_ff <= '0; plen_ff <= '0;
         prefix_ff <= '0; lead_ff <= '0; taken_ff <= '0;
      end else if (take) begin
         mode_ff <= mode_in; line_ff <= line_in; col_ff <= col_in; pos_ff <= pos_in;
         sline_ff <= sline_in; scol_ff <= scol_in; spos_ff <= spos_in;
         plen_ff <= plen_in; prefix_ff <= prefix_in; lead_ff <= lead_in;
         taken_ff <= taken_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/cst_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Token queue
// Takes up to two tokens a cycle and hands them out one at a time, oldest
// first, from two banks of RAM with a registered output.
// ---------------------------------------------------------------------------
module cst_queue
   import cst_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [1:0] wr_count,
   input  wire token_type  wr_a,
   input  wire token_type  wr_b,
   output logic            room,
   input  wire logic       pop,
   output logic            empty,
   output token_type       head
);

   localparam int Depth = 8;
   localparam int AddrBits = $clog2(Depth);

   // Even slots in bank zero, odd slots in bank one.
   logic [AddrBits:0]   wp_ff, rp_ff, cnt_ff, wp_in, rp_in, cnt_in;
   logic                fetch, hvalid_ff, hvalid_in;
   logic [AddrBits:0]   rd_slot;
   logic                last_bank_ff;
   token_type           q0, q1, d0, d1;
   logic                we0, we1;
   logic [AddrBits-2:0] wa0, wa1;
   logic [AddrBits:0]   wp1;

   always_comb begin
      wp1 = wp_ff + 1'b1;
      we0 = 1'b0; we1 = 1'b0; d0 = wr_a; d1 = wr_a;
      wa0 = wp_ff[AddrBits-1:1]; wa1 = wp_ff[AddrBits-1:1];
      if (wr_count != 2'd0) begin
         if (wp_ff[0]) begin
            we1 = 1'b1; d1 = wr_a; wa1 = wp_ff[AddrBits-1:1];
            if (wr_count == 2'd2) begin
               we0 = 1'b1; d0 = wr_b; wa0 = wp1[AddrBits-1:1];
            end
         end else begin
            we0 = 1'b1; d0 = wr_a; wa0 = wp_ff[AddrBits-1:1];
            if (wr_count == 2'd2) begin
               we1 = 1'b1; d1 = wr_b; wa1 = wp_ff[AddrBits-1:1];
            end
         end
      end
   end

   cst_ram #(.Width(TokenBits), .Depth(Depth / 2)) u_bank0 (
      .clock(clock), .wr_en(we0), .wr_addr(wa0), .wr_data(d0),
      .rd_addr(rd_slot[AddrBits-1:1]), .rd_data(q0)
   );
   cst_ram #(.Width(TokenBits), .Depth(Depth / 2)) u_bank1 (
      .clock(clock), .wr_en(we1), .wr_addr(wa1), .wr_data(d1),
      .rd_addr(rd_slot[AddrBits-1:1]), .rd_data(q1)
   );

   // Pointer and head-register control. The head register is refilled from
   // stored entries only; count covers entries not yet fetched.
   always_comb begin
      fetch = (cnt_ff != '0) && (!hvalid_ff || pop);
      rd_slot = rp_ff;
      wp_in = wp_ff + {{(AddrBits - 1){1'b0}}, wr_count};
      rp_in = fetch ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + {{(AddrBits - 1){1'b0}}, wr_count} - {{AddrBits{1'b0}}, fetch};
      hvalid_in = fetch ? 1'b1 : (pop ? 1'b0 : hvalid_ff);
      room = cnt_ff <= (AddrBits + 1)'(Depth - 4);
   end

   // The RAM is read every cycle, so head_ff keeps a fetched head after the read data moves on.
   token_type head_ff;
   logic      fresh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; hvalid_ff <= 1'b0;
         fresh_ff <= 1'b0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in; hvalid_ff <= hvalid_in;
         fresh_ff <= fetch;
      end
      if (fetch) last_bank_ff <= rp_ff[0];
      if (fresh_ff) head_ff <= last_bank_ff ? q1 : q0;
   end

   always_comb begin
      head = fresh_ff ? (last_bank_ff ? q1 : q0) : head_ff;
      empty = !hvalid_ff;
   end

endmodule
`default_nettype wire

// ===== rtl/core/c_source_tokenizer_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// C source tokenizer
// Streaming lexer: one source byte in, zero to two tokens out.
// ---------------------------------------------------------------------------
//  channel  | ports                         | handshake
//  input    | req_text_byte, req_end_of_text | req_push / req_full
//  result   | rsp_token_* fields            | rsp_pop / rsp_empty
//
// One byte is scanned per cycle while full is low; the scan state loop in the
// front part sets that rate. Tokens enter an eight-entry queue and reach the
// result ports once fetched from its RAM banks into the head register. Full
// rises while more than four entries wait in the queue, so a byte that yields
// two tokens always fits. Reset clears the scan state and empties the queue.
module c_source_tokenizer_core
   import cst_pkg::*;
#(
   parameter int TEXT_LIMIT = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_end_of_text,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [2:0]       rsp_token_kind,
   output logic [15:0]      rsp_token_line,
   output logic [15:0]      rsp_token_column,
   output logic [15:0]      rsp_start_offset,
   output logic [15:0]      rsp_token_length,
   output logic [7:0]       rsp_first_char,
   output logic             rsp_is_last
);

   logic      take, room;
   logic [1:0] cnt, wr_count;
   token_type ta, tb, head;

   assign take = req_push && !req_full;
   assign req_full = !room;
   assign wr_count = take ? cnt : 2'd0;

   cst_front #(.TextLimit(TEXT_LIMIT)) u_front (
      .clock(clock), .reset(reset), .take(take), .text_byte(req_text_byte),
      .end_of_text(req_end_of_text), .tok_count(cnt), .tok_a(ta), .tok_b(tb)
   );

   cst_queue u_queue (
      .clock(clock), .reset(reset), .wr_count(wr_count), .wr_a(ta), .wr_b(tb),
      .room(room), .pop(rsp_pop && !rsp_empty), .empty(rsp_empty), .head(head)
   );

   // Result fields.
   assign rsp_token_kind   = head.kind;
   assign rsp_token_line   = head.line;
   assign rsp_token_column = head.column;
   assign rsp_start_offset = head.offset;
   assign rsp_token_length = head.length;
   assign rsp_first_char   = head.first;
   assign rsp_is_last      = head.last;

   // An end token always carries a length of zero.
   a_end_len: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_token_kind == KIND_END) |-> rsp_token_length == 16'd0)
      else $error("end token with nonzero length");
   // An end token always closes the results of its byte.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_token_kind == KIND_END) |-> rsp_is_last)
      else $error("end token not marked last");
   // Nothing is accepted while full.
   a_full: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !take)
      else $error("byte taken while full");

endmodule
`default_nettype wire
